### rtl/tce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tce_pkg
// Shared constants, payload structs and controller/datapath bundles for the
// text console engine.
// ----------------------------------------------------------------------------
package tce_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = ($clog2(COLUMNS + 1) > 7) ? $clog2(COLUMNS + 1) : 7;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_COL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_LINE = 2'd2;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_BKSP  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_console_in;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_pos;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } t_console_out;

    typedef struct packed {
        logic accept;
        logic step;
        logic scroll_start;
        logic scroll;
        logic cnt_clr;
        logic cnt_inc;
        logic fill;
        logic fill_zero;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       is_newline;
        logic       scroll_needed;
        logic       cnt_last;
        logic       cnt_scroll_end;
    } t_dp_status;

endpackage
`default_nettype wire

### rtl/tce_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tce_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

### rtl/tce_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tce_ctrl
// Sequencer for the console: clearing pass after reset, decode, scroll copy,
// row and screen fill, and result hand-off.
// ----------------------------------------------------------------------------
module tce_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire tce_pkg::t_dp_status i_status,
    output tce_pkg::t_dp_cmd         o_cmd,
    output logic                     o_busy
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_PUT    = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.fill      = 1'b1;
                o_cmd.fill_zero = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_status.func)
                    tce_pkg::FUNC_PUT: begin
                        if (i_status.scroll_needed) begin
                            o_cmd.scroll_start = 1'b1;
                            n_state            = ST_SCROLL;
                        end else begin
                            o_cmd.step = 1'b1;
                            n_state    = ST_FINISH;
                        end
                    end
                    tce_pkg::FUNC_BKSP: begin
                        o_cmd.step = 1'b1;
                        n_state    = ST_FINISH;
                    end
                    tce_pkg::FUNC_CLEAR: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = ST_FILL;
                    end
                    tce_pkg::FUNC_READ: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_SCROLL: begin
                o_cmd.scroll = 1'b1;
                if (i_status.cnt_scroll_end) begin
                    n_state = ST_FILL;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            ST_FILL: begin
                o_cmd.fill    = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_status.cnt_last) begin
                    if (i_status.func == tce_pkg::FUNC_PUT && !i_status.is_newline) begin
                        n_state = ST_PUT;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_PUT: begin
                o_cmd.step = 1'b1;
                n_state    = ST_FINISH;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule
`default_nettype wire

### rtl/tce_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tce_datapath
// Cursor and configuration registers, sweep counter, screen memory port
// muxing and result register.
// ----------------------------------------------------------------------------
module tce_datapath (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire tce_pkg::t_console_in                 i_in,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [tce_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [tce_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire tce_pkg::t_dp_cmd                     i_cmd,
    output tce_pkg::t_dp_status                       o_status,
    output tce_pkg::t_console_out                     o_result,
    output logic                                      o_done
);

    localparam int AW = tce_pkg::ADDR_W;
    localparam int CW = tce_pkg::COL_W;
    localparam int RW = tce_pkg::ROW_W;

    logic [CW-1:0]                 r_col;
    logic [CW-1:0]                 n_col;
    logic [RW-1:0]                 r_row;
    logic [RW-1:0]                 n_row;
    logic [AW-1:0]                 r_cnt;
    logic [AW-1:0]                 n_cnt;
    logic [tce_pkg::ATTR_W-1:0]    r_attr;
    logic [6:0]                    r_prompt_col;
    logic [4:0]                    r_prompt_line;
    tce_pkg::t_console_in          r_in;
    tce_pkg::t_console_out         r_out;
    logic                          r_done;

    logic                          step_we;
    logic [CW-1:0]                 step_col;
    logic [RW-1:0]                 step_row;
    logic [tce_pkg::CELL_W-1:0]    step_data;
    logic [tce_pkg::CELL_W-1:0]    blank;
    logic                          at_prompt;

    logic                          ram_we;
    logic [AW-1:0]                 ram_wr_addr;
    logic [tce_pkg::CELL_W-1:0]    ram_wr_data;
    logic [AW-1:0]                 ram_rd_addr;
    logic [tce_pkg::CELL_W-1:0]    ram_rd_data;

    tce_ram #(
        .WIDTH (tce_pkg::CELL_W),
        .DEPTH (tce_pkg::CELL_COUNT)
    ) u_screen (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign blank     = {r_attr, tce_pkg::SPACE_CODE};
    assign at_prompt = (32'(r_row) == 32'(r_prompt_line))
                       && (32'(r_col) <= 32'(r_prompt_col));

    // cursor update for put and backspace
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        step_we   = 1'b0;
        step_col  = r_col;
        step_row  = r_row;
        step_data = {r_attr, r_in.char_code};
        if (i_cmd.scroll_start) begin
            n_col = '0;
        end
        if (i_cmd.step) begin
            unique case (r_in.func)
                tce_pkg::FUNC_PUT: begin
                    if (r_in.char_code == tce_pkg::NEWLINE_CODE) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else if (32'(r_col) >= tce_pkg::COLUMNS) begin
                        n_col    = CW'(1);
                        n_row    = r_row + 1'b1;
                        step_we  = 1'b1;
                        step_col = '0;
                        step_row = r_row + 1'b1;
                    end else begin
                        n_col   = r_col + 1'b1;
                        step_we = 1'b1;
                    end
                end
                tce_pkg::FUNC_BKSP: begin
                    step_data = blank;
                    if (at_prompt) begin
                        n_col = r_col;
                    end else if (r_col != '0) begin
                        n_col    = r_col - 1'b1;
                        step_col = r_col - 1'b1;
                        step_we  = (32'(r_col) - 32'd1 < tce_pkg::COLUMNS);
                    end else if (r_row != '0) begin
                        n_row    = r_row - 1'b1;
                        step_row = r_row - 1'b1;
                        if ((32'(r_row) - 32'd1 == 32'(r_prompt_line))
                            && (tce_pkg::COLUMNS - 1 < 32'(r_prompt_col))) begin
                            n_col = CW'(r_prompt_col);
                        end else begin
                            n_col    = CW'(tce_pkg::COLUMNS - 1);
                            step_col = CW'(tce_pkg::COLUMNS - 1);
                            step_we  = 1'b1;
                        end
                    end
                end
                tce_pkg::FUNC_CLEAR: begin
                    n_col = r_col;
                end
                tce_pkg::FUNC_READ: begin
                    n_col = r_col;
                end
            endcase
        end
    end

    // memory port selection
    always_comb begin
        if (i_cmd.fill) begin
            ram_we      = 1'b1;
            ram_wr_addr = r_cnt;
            ram_wr_data = i_cmd.fill_zero ? '0 : blank;
        end else if (i_cmd.scroll) begin
            ram_we      = (r_cnt != '0);
            ram_wr_addr = r_cnt - 1'b1;
            ram_wr_data = ram_rd_data;
        end else begin
            ram_we      = step_we;
            ram_wr_addr = AW'(32'(step_row) * tce_pkg::COLUMNS + 32'(step_col));
            ram_wr_data = step_data;
        end
        ram_rd_addr = i_cmd.scroll ? r_cnt + AW'(tce_pkg::COLUMNS) : AW'(r_in.cell_index);
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.cnt_clr || i_cmd.scroll_start) begin
            n_cnt = '0;
        end else if (i_cmd.cnt_inc) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_row         <= '0;
            r_cnt         <= '0;
            r_attr        <= tce_pkg::ATTR_RESET;
            r_prompt_col  <= '0;
            r_prompt_line <= '0;
            r_done        <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_cnt  <= n_cnt;
            r_done <= i_cmd.finish;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    tce_pkg::CFG_TEXT_ATTR:   r_attr        <= i_cfg_data;
                    tce_pkg::CFG_PROMPT_COL:  r_prompt_col  <= i_cfg_data[6:0];
                    tce_pkg::CFG_PROMPT_LINE: r_prompt_line <= i_cfg_data[4:0];
                    default: begin
                        r_attr <= r_attr;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in;
        end
        if (i_cmd.finish) begin
            r_out.cursor_col <= 7'(r_col);
            r_out.cursor_row <= 5'(r_row);
            r_out.cursor_pos <= 11'(32'(r_row) * tce_pkg::COLUMNS + 32'(r_col));
            if (r_in.func == tce_pkg::FUNC_READ
                && 32'(r_in.cell_index) < tce_pkg::CELL_COUNT) begin
                r_out.cell_char <= ram_rd_data[tce_pkg::CHAR_W-1:0];
                r_out.cell_attr <= ram_rd_data[tce_pkg::CELL_W-1:tce_pkg::CHAR_W];
            end else begin
                r_out.cell_char <= '0;
                r_out.cell_attr <= '0;
            end
        end
    end

    assign o_status.func           = r_in.func;
    assign o_status.is_newline     = (r_in.char_code == tce_pkg::NEWLINE_CODE);
    assign o_status.scroll_needed  = ((r_in.char_code == tce_pkg::NEWLINE_CODE)
                                     || (32'(r_col) >= tce_pkg::COLUMNS))
                                     && (32'(r_row) == tce_pkg::ROWS - 1);
    assign o_status.cnt_last       = (32'(r_cnt) == tce_pkg::CELL_COUNT - 1);
    assign o_status.cnt_scroll_end = (32'(r_cnt) == tce_pkg::CELL_COUNT - tce_pkg::COLUMNS);

    assign o_result = r_out;
    assign o_done   = r_done;

endmodule
`default_nettype wire

### rtl/text_console_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_engine_unit
// Text-mode console: character/attribute screen memory with cursor, put,
// backspace, clear and cell read.
//
//   channel   handshake             payload
//   command   start, busy           i_cmd   (func, char_code, cell_index)
//   result    o_done (strobe)       o_result (cursor and read cell)
//   config    i_cfg_wr_en           i_cfg_index, i_cfg_data
//
// put, backspace, newline and read without a scroll go from the accepted beat
// through decode to finish; the result strobe shows in the cycle busy drops.
// a scroll copies the screen up through the single memory port pair and
// fills the last row; clear fills every cell with blanks.
// after reset a clearing pass over all ROWS*COLUMNS cells holds busy high;
// config writes are taken at any time. results cannot be stalled.
// ----------------------------------------------------------------------------
module text_console_engine_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire tce_pkg::t_console_in           i_cmd,
    output logic                                o_done,
    output tce_pkg::t_console_out               o_result,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [tce_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tce_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tce_pkg::t_dp_cmd    dp_cmd;
    tce_pkg::t_dp_status dp_status;

    tce_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    tce_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_cmd),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_result    (o_result),
        .o_done      (o_done)
    );

    // a result beat only closes work in progress
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
    else $error("result beat without work in progress");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
    else $error("result beat repeated");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
    else $error("accepted beat did not start work");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_result.cursor_row) < tce_pkg::ROWS))
    else $error("cursor row out of screen");

endmodule
`default_nettype wire

### dv/text_console_engine_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_engine_unit_test
// Self-checking bench for the text console engine. A mirror of the screen,
// cursor and registers predicts every result beat; commands are a directed
// opening followed by random typing, newlines, backspace runs, cell reads
// and clears under several register settings, with random idle gaps.
// ----------------------------------------------------------------------------
module text_console_engine_unit_test;
    import tce_pkg::*;

    localparam int TOTAL_ITEMS    = 721;
    localparam int PHASE_ITEMS    = 100;
    localparam int WATCHDOG_LIMIT = 25000;

    class console_tracker;
        logic [CELL_W-1:0] cells [CELL_COUNT];
        int unsigned       col;
        int unsigned       row;
        logic [7:0]        text_attr;
        logic [6:0]        prompt_col;
        logic [4:0]        prompt_row;
        t_console_out      awaited[$];
        int unsigned       errors;

        function new();
            foreach (cells[i]) cells[i] = '0;
            col        = 0;
            row        = 0;
            text_attr  = ATTR_RESET;
            prompt_col = '0;
            prompt_row = '0;
            errors     = 0;
        endfunction

        function logic [CELL_W-1:0] blank();
            return {text_attr, SPACE_CODE};
        endfunction

        function void store(int unsigned c, int unsigned r, logic [CELL_W-1:0] v);
            if (c < COLUMNS && r < ROWS) cells[r * COLUMNS + c] = v;
        endfunction

        function void advance_line();
            col = 0;
            if (row < ROWS - 1) begin
                row++;
            end else begin
                for (int i = COLUMNS; i < CELL_COUNT; i++) cells[i - COLUMNS] = cells[i];
                for (int c = 0; c < COLUMNS; c++) store(c, ROWS - 1, blank());
            end
        endfunction

        function void put_char(logic [7:0] ch);
            if (ch == NEWLINE_CODE) begin
                advance_line();
            end else begin
                if (col >= COLUMNS) advance_line();
                store(col, row, {text_attr, ch});
                col++;
            end
        endfunction

        function void erase_back();
            if (row == prompt_row && col <= prompt_col) return;
            if (col > 0) begin
                col--;
                store(col, row, blank());
                return;
            end
            if (row == 0) return;
            row--;
            col = COLUMNS - 1;
            if (row == prompt_row && col < prompt_col) begin
                col = prompt_col;
                return;
            end
            store(col, row, blank());
        endfunction

        function void note_command(t_console_in cmd);
            t_console_out res;
            res = '0;
            case (cmd.func)
                FUNC_PUT: put_char(cmd.char_code);
                FUNC_BKSP: erase_back();
                FUNC_CLEAR: begin
                    foreach (cells[i]) cells[i] = blank();
                end
                default: begin
                    if (cmd.cell_index < CELL_COUNT) begin
                        res.cell_char = cells[cmd.cell_index][7:0];
                        res.cell_attr = cells[cmd.cell_index][15:8];
                    end
                end
            endcase
            res.cursor_col = 7'(col);
            res.cursor_row = 5'(row);
            res.cursor_pos = 11'(row * COLUMNS + col);
            awaited.push_back(res);
        endfunction

        function void check_field(string name, logic [10:0] want, logic [10:0] got);
            if (got !== want) begin
                $display("%0t %s expected %0d got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_console_out got);
            t_console_out want;
            if (awaited.size() == 0) begin
                $display("%0t unexpected result beat expected none got %h", $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            check_field("cursor_col", 11'(want.cursor_col), 11'(got.cursor_col));
            check_field("cursor_row", 11'(want.cursor_row), 11'(got.cursor_row));
            check_field("cursor_pos", want.cursor_pos, got.cursor_pos);
            check_field("cell_char", 11'(want.cell_char), 11'(got.cell_char));
            check_field("cell_attr", 11'(want.cell_attr), 11'(got.cell_attr));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_console_in           i_cmd       = '0;
    logic                  o_done;
    t_console_out          o_result;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    console_tracker tracker = new();
    int             sent_count   = 0;
    int             stall_cycles = 0;
    bit             idle_on      = 1'b1;
    int             phase;
    int             phase_end;

    text_console_engine_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) tracker.check_result(o_result);
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("text_console_engine_unit_test NOT OK");
            $finish;
        end
    end

    function automatic t_console_in make_cmd(logic [1:0] func, logic [7:0] ch,
                                             logic [10:0] idx);
        t_console_in cmd;
        cmd.func       = func;
        cmd.char_code  = ch;
        cmd.cell_index = idx;
        return cmd;
    endfunction

    task automatic send(t_console_in cmd);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_command(cmd);
        sent_count++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (tracker.awaited.size() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_config(logic [7:0] attr, logic [6:0] pcol, logic [4:0] pline);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_TEXT_ATTR;
        i_cfg_data  <= attr;
        @(posedge i_clk);
        i_cfg_index <= CFG_PROMPT_COL;
        i_cfg_data  <= {1'b0, pcol};
        @(posedge i_clk);
        i_cfg_index <= CFG_PROMPT_LINE;
        i_cfg_data  <= {3'b000, pline};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.text_attr  = attr;
        tracker.prompt_col = pcol;
        tracker.prompt_row = pline;
    endtask

    function automatic logic [7:0] any_char();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [10:0] any_index();
        return 11'($urandom_range(0, 2047));
    endfunction

    task automatic run_random_sequence();
        int kind;
        int n;
        int idx;
        idle_on = ($urandom_range(0, 3) != 0);
        kind    = $urandom_range(0, 99);
        if (kind < 40) begin
            // typed line, sometimes long enough to wrap
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 95) : $urandom_range(0, 20);
            repeat (n) send(make_cmd(FUNC_PUT, any_char(), any_index()));
            if ($urandom_range(0, 9) < 8) send(make_cmd(FUNC_PUT, NEWLINE_CODE, any_index()));
        end else if (kind < 50) begin
            repeat ($urandom_range(1, 6)) send(make_cmd(FUNC_PUT, NEWLINE_CODE, any_index()));
        end else if (kind < 70) begin
            repeat ($urandom_range(1, 8)) send(make_cmd(FUNC_BKSP, any_char(), any_index()));
        end else if (kind < 92) begin
            repeat ($urandom_range(1, 4)) begin
                idx = int'(tracker.row * COLUMNS + tracker.col) - $urandom_range(0, 3);
                if ($urandom_range(0, 1) == 0) idx = $urandom_range(0, 2047);
                if (idx < 0) idx = 0;
                send(make_cmd(FUNC_READ, any_char(), 11'(idx)));
            end
        end else if (kind < 95) begin
            send(make_cmd(FUNC_CLEAR, any_char(), any_index()));
        end else begin
            send(make_cmd(2'($urandom_range(0, 3)), any_char(), any_index()));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // top-left, prompt on another row
        write_config(8'h1E, 7'd3, 5'd5);
        send(make_cmd(FUNC_BKSP, 8'h00, 11'd0));
        send(make_cmd(FUNC_READ, 8'h00, 11'd0));
        send(make_cmd(FUNC_READ, 8'hFF, 11'd2047));
        send(make_cmd(FUNC_PUT, 8'h00, 11'd0));
        send(make_cmd(FUNC_PUT, 8'hFF, 11'd0));
        send(make_cmd(FUNC_PUT, 8'h41, 11'd0));
        send(make_cmd(FUNC_BKSP, 8'h00, 11'd0));
        send(make_cmd(FUNC_READ, 8'h00, 11'd2));
        send(make_cmd(FUNC_PUT, NEWLINE_CODE, 11'd0));
        send(make_cmd(FUNC_BKSP, 8'h00, 11'd0));
        send(make_cmd(FUNC_PUT, 8'h80, 11'd0));
        send(make_cmd(FUNC_PUT, 8'h42, 11'd0));
        send(make_cmd(FUNC_READ, 8'h00, 11'd80));
        send(make_cmd(FUNC_CLEAR, 8'h00, 11'd0));
        send(make_cmd(FUNC_READ, 8'h00, 11'd1999));
        drain();

        // backspace into the prompt, cursor parked beyond the row
        write_config(8'hF0, 7'd127, 5'd0);
        send(make_cmd(FUNC_BKSP, 8'h00, 11'd0));
        send(make_cmd(FUNC_BKSP, 8'h00, 11'd0));
        send(make_cmd(FUNC_BKSP, 8'h00, 11'd0));
        drain();

        // prompt moved away: backspace beyond the row, then put starts a new line
        write_config(8'hFF, 7'd0, 5'd31);
        send(make_cmd(FUNC_BKSP, 8'h00, 11'd0));
        send(make_cmd(FUNC_PUT, SPACE_CODE, 11'd0));
        send(make_cmd(FUNC_READ, 8'h00, 11'd80));
        drain();

        phase = 0;
        while (sent_count < TOTAL_ITEMS) begin
            case (phase)
                0: write_config(8'h00, 7'd79, 5'd24);
                1: write_config(8'hFF, 7'd80, 5'd0);
                2: write_config(8'hA5, 7'd127, 5'd12);
                default: write_config(8'($urandom_range(0, 255)),
                                      ($urandom_range(0, 3) == 0) ? 7'($urandom_range(80, 127))
                                                                  : 7'($urandom_range(0, 79)),
                                      5'($urandom_range(0, 24)));
            endcase
            phase_end = sent_count + PHASE_ITEMS;
            while (sent_count < phase_end && sent_count < TOTAL_ITEMS) run_random_sequence();
            drain();
            phase++;
        end

        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("text_console_engine_unit_test OK");
        end else begin
            $display("text_console_engine_unit_test NOT OK");
        end
        $finish;
    end

endmodule

### files.f
rtl/tce_pkg.sv
rtl/tce_ram.sv
rtl/tce_ctrl.sv
rtl/tce_datapath.sv
rtl/text_console_engine_unit.sv
dv/text_console_engine_unit_test.sv
